>>> rtl/nts_pkg.sv
// Shared types, character codes and helper functions of the numeric token scanner.
package nts_pkg;

    // Mode codes of the input word
    localparam logic [1:0] MODE_DEC32 = 2'd0;
    localparam logic [1:0] MODE_HEX32 = 2'd1;
    localparam logic [1:0] MODE_DEC64 = 2'd2;
    localparam logic [1:0] MODE_RSVD  = 2'd3;

    // Run limits, in bytes
    localparam logic [4:0] RUN_LIMIT_32 = 5'd23;
    localparam logic [4:0] RUN_LIMIT_64 = 5'd20;

    // Character codes
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_F_UP  = 8'h46;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_F_LO  = 8'h66;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_X_LO  = 8'h78;

    // Result buffer geometry
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] text_byte;
        logic [1:0] mode;
        logic       end_of_text;
    } t_in_word;

    typedef struct packed {
        logic signed [63:0] value;
        logic               found;
        logic               saturated;
        logic               last_of_run;
    } t_out_word;

    // Results of one byte: up to two words, first in order
    typedef struct packed {
        logic [1:0] count;
        t_out_word  first;
        t_out_word  second;
    } t_step_res;

    typedef enum logic [5:0] {
        PH_SIGN         = 6'b000001,
        PH_AFTER_SIGN   = 6'b000010,
        PH_LEAD_ZERO    = 6'b000100,
        PH_AFTER_PREFIX = 6'b001000,
        PH_DIGITS       = 6'b010000,
        PH_STOP         = 6'b100000
    } t_phase;

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Returns {valid, digit value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (is_dec(c)) begin
            r = {1'b1, c[3:0]};
        end else if (((c >= CH_A_UP) && (c <= CH_F_UP)) ||
                     ((c >= CH_A_LO) && (c <= CH_F_LO))) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic logic is_member(input logic [1:0] mode, input logic [7:0] c);
        logic [4:0] h;
        h = hex_digit(c);
        if (mode == MODE_HEX32) begin
            return h[4] || (c == CH_MINUS) || (c == CH_DOT) ||
                   (c == CH_X_LO) || (c == CH_X_UP);
        end
        return is_dec(c) || (c == CH_MINUS);
    endfunction

    // Final value of a token from its magnitude, sign and overflow flag
    function automatic logic [63:0] tok_value(input logic [1:0] mode, input logic neg,
                                              input logic ovf, input logic [63:0] acc);
        logic [63:0] mag;
        mag = neg ? (64'd0 - acc) : acc;
        if (mode == MODE_HEX32) begin
            return ovf ? {32'd0, 32'hFFFF_FFFF} : {32'd0, mag[31:0]};
        end
        return mag;
    endfunction

endpackage

>>> rtl/numeric_token_scanner.sv
// Numeric token scanner: input register, conversion core and result buffer.
// Flow: a byte accepted into the input register is converted when the result buffer
// can take two words; its result words are written into the buffer and offered from there.
// Throughput: one byte per cycle while each byte yields at most one word and the
// output is taken; a two-word byte sends both through the single output port in turn.
// Reset (synchronous, active low) closes any open token and empties the buffer.
module numeric_token_scanner
    import nts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    logic                 r_in_vld;
    t_in_word             r_in_word;
    t_out_word            r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [FIFO_CW-1:0]   r_cnt;

    logic [FIFO_CW-1:0]   n_cnt;
    logic                 proceed, pop;
    logic [1:0]           push_n;
    t_step_res            res;

    // The core steps only when the buffer can take two words.
    assign proceed    = r_in_vld && (r_cnt <= FIFO_CW'(FIFO_DEPTH - 2));
    assign o_in_ready = !r_in_vld || proceed;
    assign pop        = o_out_valid && i_out_ready;
    assign push_n     = proceed ? res.count : 2'd0;
    assign n_cnt      = r_cnt + FIFO_CW'(push_n) - FIFO_CW'(pop);

    assign o_out_valid = (r_cnt != '0);
    assign o_out_word  = r_fifo[r_rd_ptr];

    nts_core u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (proceed),
        .i_word (r_in_word),
        .o_res  (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            r_wr_ptr <= r_wr_ptr + FIFO_AW'(push_n);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
        if (push_n != 2'd0) begin
            r_fifo[r_wr_ptr] <= res.first;
        end
        if (push_n == 2'd2) begin
            r_fifo[r_wr_ptr + FIFO_AW'(1)] <= res.second;
        end
    end

endmodule

>>> rtl/nts_core.sv
// Per-byte token state and conversion step of the numeric token scanner.
module nts_core
    import nts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_word  i_word,
    output t_step_res o_res
);

    logic        r_in_token;
    logic [1:0]  r_mode;
    logic [4:0]  r_count;
    t_phase      r_phase;
    logic        r_neg;
    logic [63:0] r_acc;
    logic        r_ovf;

    logic        n_in_token;
    logic [7:0]  c;
    logic [1:0]  m_eff;
    logic        still, emit_a, start, in_run, emit_b, emit_c, in_keep, not_found;
    logic        has_s;
    logic [1:0]  s_mode;
    logic [4:0]  s_count, f_count;
    t_phase      s_phase, f_phase;
    logic        s_neg, f_neg, s_ovf, f_ovf;
    logic [63:0] s_acc, f_acc;
    logic [4:0]  hex;
    logic        do_acc;
    logic [63:0] bound;
    logic [67:0] wide;
    logic [4:0]  limit;
    t_out_word   w_a, w_s, w_nf;

    always_comb begin
        c      = i_word.text_byte;
        m_eff  = (i_word.mode == MODE_RSVD) ? MODE_DEC32 : i_word.mode;
        still  = r_in_token && is_member(r_mode, c);
        emit_a = r_in_token && !still;
        start  = !still && is_member(m_eff, c);
        in_run = still || start;

        if (start) begin
            s_mode  = m_eff;
            s_count = 5'd0;
            s_phase = PH_SIGN;
            s_neg   = 1'b0;
            s_acc   = 64'd0;
            s_ovf   = 1'b0;
        end else begin
            s_mode  = r_mode;
            s_count = r_count;
            s_phase = r_phase;
            s_neg   = r_neg;
            s_acc   = r_acc;
            s_ovf   = r_ovf;
        end

        // Conversion phase walk, strtol style
        hex     = hex_digit(c);
        do_acc  = 1'b0;
        f_phase = s_phase;
        f_neg   = s_neg;
        if (s_phase != PH_STOP) begin
            if ((s_phase == PH_SIGN) && (c == CH_MINUS)) begin
                f_neg   = 1'b1;
                f_phase = PH_AFTER_SIGN;
            end else if (s_mode != MODE_HEX32) begin
                if (is_dec(c)) begin
                    do_acc  = 1'b1;
                    f_phase = PH_DIGITS;
                end else begin
                    f_phase = PH_STOP;
                end
            end else if (((s_phase == PH_SIGN) || (s_phase == PH_AFTER_SIGN)) &&
                         (c == CH_ZERO)) begin
                f_phase = PH_LEAD_ZERO;
            end else if ((s_phase == PH_LEAD_ZERO) && ((c == CH_X_LO) || (c == CH_X_UP))) begin
                f_phase = PH_AFTER_PREFIX;
            end else if (hex[4]) begin
                do_acc  = 1'b1;
                f_phase = PH_DIGITS;
            end else begin
                f_phase = PH_STOP;
            end
        end

        case (s_mode)
            MODE_HEX32: bound = 64'h0000_0000_FFFF_FFFF;
            MODE_DEC64: bound = s_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            default:    bound = s_neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
        endcase

        // acc * base + digit, compared with the bound, replaces the division test
        if (s_mode == MODE_HEX32) begin
            wide = {s_acc, 4'd0};
        end else begin
            wide = {1'b0, s_acc, 3'd0} + {3'd0, s_acc, 1'b0};
        end
        wide = wide + {64'd0, hex[3:0]};

        f_acc = s_acc;
        f_ovf = s_ovf;
        if (do_acc && !s_ovf) begin
            if (wide > {4'd0, bound}) begin
                f_ovf = 1'b1;
                f_acc = bound;
            end else begin
                f_acc = wide[63:0];
            end
        end

        f_count = s_count + 5'd1;
        limit   = (s_mode == MODE_DEC64) ? RUN_LIMIT_64 : RUN_LIMIT_32;
        emit_b  = in_run && (f_count >= limit);
        in_keep = in_run && !emit_b;
        emit_c  = i_word.end_of_text && in_keep;
        has_s   = emit_b || emit_c;
        not_found = i_word.end_of_text && !emit_a && !has_s;
        n_in_token = in_keep && !i_word.end_of_text;

        w_a.value       = $signed(tok_value(r_mode, r_neg, r_ovf, r_acc));
        w_a.found       = 1'b1;
        w_a.saturated   = r_ovf;
        w_a.last_of_run = !has_s;
        w_s.value       = $signed(tok_value(s_mode, f_neg, f_ovf, f_acc));
        w_s.found       = 1'b1;
        w_s.saturated   = f_ovf;
        w_s.last_of_run = 1'b1;
        w_nf.value       = 64'sd0;
        w_nf.found       = 1'b0;
        w_nf.saturated   = 1'b0;
        w_nf.last_of_run = 1'b1;

        o_res.count  = {1'b0, emit_a} + {1'b0, has_s} + {1'b0, not_found};
        o_res.first  = emit_a ? w_a : (has_s ? w_s : w_nf);
        o_res.second = w_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_token <= 1'b0;
            r_mode     <= MODE_DEC32;
            r_count    <= 5'd0;
            r_phase    <= PH_SIGN;
            r_neg      <= 1'b0;
            r_acc      <= 64'd0;
            r_ovf      <= 1'b0;
        end else if (i_step) begin
            r_in_token <= n_in_token;
            if (in_run) begin
                r_mode  <= s_mode;
                r_count <= f_count;
                r_phase <= f_phase;
                r_neg   <= f_neg;
                r_acc   <= f_acc;
                r_ovf   <= f_ovf;
            end
        end
    end

endmodule

>>> rtl/nts_checker.sv
// Port-level assertions of the numeric token scanner and their bind.
module nts_checker
    import nts_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid right after reset");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_word))
        else $error("stalled input word changed or dropped");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed or dropped");

    // With nothing buffered the scanner always has room for the next byte.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while result buffer empty");

    a_not_found_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.found |->
            o_out_word.last_of_run && !o_out_word.saturated && (o_out_word.value == 64'sd0))
        else $error("malformed not-found word");

endmodule

bind numeric_token_scanner nts_checker u_nts_checker (.*);
